// File: hw/rtl/flot_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-latency offload tracker package
// Shared widths, register indexes, result codes and structs.
// ----------------------------------------------------------------------------
package flot_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned TIME_W   = 64;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned MAXO_W   = 5;
	localparam int unsigned LAT_W    = 32;
	localparam int unsigned OCC_W    = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [MAXO_W-1:0] MAXO_RESET = MAXO_W'(16);
	localparam logic [LAT_W-1:0]  LAT_RESET  = '0;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_OUTSTANDING = 1'd0,
		REG_OFFLOAD_LATENCY = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SUBMIT_NONE     = 2'd0,
		SUBMIT_ACCEPTED = 2'd1,
		SUBMIT_REJECTED = 2'd2
	} submit_t;

	typedef struct packed {
		logic [MAXO_W-1:0] max_outstanding;
		logic [LAT_W-1:0]  offload_latency;
	} cfg_t;

	typedef struct packed {
		logic              fire;
		logic [TIME_W-1:0] now;
		logic              request;
		logic [ADDR_W-1:0] record_addr;
	} step_t;

	typedef struct packed {
		logic              done_res;
		logic [ADDR_W-1:0] done_addr;
		submit_t           submit_result;
		logic [OCC_W-1:0]  occupancy;
	} result_t;

endpackage

// File: hw/rtl/flot_if.sv
// ----------------------------------------------------------------------------
// Fixed-latency offload tracker channel interfaces
// Valid/ready channels for steps, results and register writes.
// ----------------------------------------------------------------------------
interface flot_in_if;
	logic                            valid;
	logic                            ready;
	logic [flot_pkg::TIME_W-1:0]     now;
	logic                            request;
	logic [flot_pkg::ADDR_W-1:0]     record_addr;

	modport source (output valid, output now, output request, output record_addr,
		input ready);
	modport sink (input valid, input now, input request, input record_addr,
		output ready);
endinterface

interface flot_out_if;
	logic                            valid;
	logic                            ready;
	logic                            done_res;
	logic [flot_pkg::ADDR_W-1:0]     done_addr;
	logic [1:0]                      submit_result;
	logic [flot_pkg::OCC_W-1:0]      occupancy;

	modport source (output valid, output done_res, output done_addr,
		output submit_result, output occupancy, input ready);
	modport sink (input valid, input done_res, input done_addr,
		input submit_result, input occupancy, output ready);
endinterface

interface flot_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [flot_pkg::CFG_IDX_W-1:0]      index;
	logic [flot_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/flot_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module flot_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/flot_cfg.sv
// ----------------------------------------------------------------------------
// Fixed-latency offload tracker configuration registers
// Decodes register writes into the limit and latency registers.
// ----------------------------------------------------------------------------
module flot_cfg (
	input  logic              clk,
	input  logic              arst_n,
	flot_cfg_if.sink          cfg_ch,
	output flot_pkg::cfg_t    cfg
);

	logic [flot_pkg::MAXO_W-1:0] max_outstanding_q;
	logic [flot_pkg::LAT_W-1:0]  offload_latency_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_outstanding_q <= flot_pkg::MAXO_RESET;
			offload_latency_q <= flot_pkg::LAT_RESET;
		end else if (cfg_ch.valid) begin
			unique case (flot_pkg::cfg_reg_t'(cfg_ch.index))
				flot_pkg::REG_MAX_OUTSTANDING: begin
					max_outstanding_q <= cfg_ch.data[flot_pkg::MAXO_W-1:0];
				end
				flot_pkg::REG_OFFLOAD_LATENCY: begin
					offload_latency_q <= cfg_ch.data[flot_pkg::LAT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.max_outstanding = max_outstanding_q;
	assign cfg.offload_latency = offload_latency_q;

endmodule

// File: hw/rtl/flot_core.sv
// ----------------------------------------------------------------------------
// Fixed-latency offload tracker queue core
// In-order queue of due times and record addresses with head compare.
// ----------------------------------------------------------------------------
module flot_core #(
	parameter int unsigned QUEUE_DEPTH = flot_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  flot_pkg::cfg_t    cfg,
	input  flot_pkg::step_t   step,
	output flot_pkg::result_t res
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > flot_pkg::MAXO_W) ? CNT_W : flot_pkg::MAXO_W;
	localparam int unsigned ENT_W = flot_pkg::TIME_W + flot_pkg::ADDR_W;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(QUEUE_DEPTH);

	logic [PTR_W-1:0] head_ptr_q, tail_ptr_q, head_ptr_d, tail_ptr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             fwd_q;
	logic [ENT_W-1:0] fwd_data_q;

	logic [ENT_W-1:0]              ram_rdata, head_ent, wr_ent;
	logic [flot_pkg::TIME_W-1:0]   head_due;
	logic [flot_pkg::ADDR_W-1:0]   head_addr;
	logic                          pop, push, we;
	logic [CMP_W-1:0]              count_mid, limit, maxo_ext;

	// The RAM returns the old word when the head slot is written in the same
	// cycle it is read, so that word is forwarded from a register instead.
	assign head_ent  = fwd_q ? fwd_data_q : ram_rdata;
	assign head_due  = head_ent[ENT_W-1 -: flot_pkg::TIME_W];
	assign head_addr = head_ent[flot_pkg::ADDR_W-1:0];

	assign pop       = (count_q != '0) && (step.now >= head_due);
	assign count_mid = CMP_W'(count_q) - CMP_W'(pop);
	assign maxo_ext  = CMP_W'(cfg.max_outstanding);
	assign limit     = (maxo_ext > DEPTH_C) ? DEPTH_C : maxo_ext;
	assign push      = step.request && (count_mid < limit);
	assign we        = step.fire && push;

	assign wr_ent = {step.now + flot_pkg::TIME_W'(cfg.offload_latency), step.record_addr};

	always_comb begin
		head_ptr_d = head_ptr_q;
		tail_ptr_d = tail_ptr_q;
		count_d    = count_q;
		if (step.fire) begin
			if (pop) begin
				head_ptr_d = (head_ptr_q == LAST_PTR) ? '0 : head_ptr_q + 1'b1;
			end
			if (push) begin
				tail_ptr_d = (tail_ptr_q == LAST_PTR) ? '0 : tail_ptr_q + 1'b1;
			end
			count_d = CNT_W'(count_mid + CMP_W'(push));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			count_q    <= '0;
			fwd_q      <= 1'b0;
		end else begin
			head_ptr_q <= head_ptr_d;
			tail_ptr_q <= tail_ptr_d;
			count_q    <= count_d;
			fwd_q      <= we && (tail_ptr_q == head_ptr_d);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_ent;
	end

	flot_ram #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH),
		.AW    (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tail_ptr_q),
		.wdata (wr_ent),
		.raddr (head_ptr_d),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic [CMP_W-1:0] count_after;
		count_after       = count_mid + CMP_W'(push);
		res.done_res      = pop;
		res.done_addr     = pop ? head_addr : '0;
		res.submit_result = !step.request ? flot_pkg::SUBMIT_NONE :
			push ? flot_pkg::SUBMIT_ACCEPTED : flot_pkg::SUBMIT_REJECTED;
		res.occupancy     = count_after[flot_pkg::OCC_W-1:0];
	end

endmodule

// File: hw/rtl/fixed_latency_offload_tracker.sv
// ----------------------------------------------------------------------------
// Fixed-latency offload tracker
// Tracks offloads that all finish a fixed latency after submission.
// ----------------------------------------------------------------------------
// Every input transaction is one polling step and yields exactly one result
// transaction. A step first retires the oldest offload if its due time has
// been reached, then takes or rejects a new submission against the limit in
// max_outstanding (capped at QUEUE_DEPTH), stamping it with now plus
// offload_latency. The block takes one step per clock cycle while the
// receiver takes each result: a step is registered at the input, resolved
// combinationally against the queue head (one 64-bit compare and one 64-bit
// add) and registered at the output. A result that the receiver holds off
// keeps the step behind it waiting in the input register, and the input then
// stalls. The queue lives in a two-port RAM of QUEUE_DEPTH entries whose head
// word is read ahead at the next head pointer. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fixed_latency_offload_tracker #(
	parameter int unsigned QUEUE_DEPTH = flot_pkg::QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	flot_in_if.sink   in_ch,
	flot_out_if.source out_ch,
	flot_cfg_if.sink  cfg_ch
);

	logic                          valid_s1;
	logic [flot_pkg::TIME_W-1:0]   now_s1;
	logic                          request_s1;
	logic [flot_pkg::ADDR_W-1:0]   addr_s1;

	logic                          out_valid_q;
	flot_pkg::result_t             res_q;

	flot_pkg::cfg_t                cfg;
	flot_pkg::step_t               step;
	flot_pkg::result_t             res;
	logic                          fire;

	assign fire        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			now_s1     <= in_ch.now;
			request_s1 <= in_ch.request;
			addr_s1    <= in_ch.record_addr;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	assign step.fire        = fire;
	assign step.now         = now_s1;
	assign step.request     = request_s1;
	assign step.record_addr = addr_s1;

	flot_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	flot_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.res    (res)
	);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.done_res      = res_q.done_res;
	assign out_ch.done_addr     = res_q.done_addr;
	assign out_ch.submit_result = res_q.submit_result;
	assign out_ch.occupancy     = res_q.occupancy;

endmodule
